[rtl/core/spq_pkg.sv]
package spq_pkg;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_POP    = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one command transfer
	typedef struct packed {
		logic               opcode;
		logic signed [31:0] value;
	} cmd_t;

	// one result transfer
	typedef struct packed {
		logic signed [31:0] popped_value;
		logic               popped_valid;
		logic [1:0]         status;
		logic [4:0]         entry_count;
	} result_t;

	// control broadcast to every cell
	typedef struct packed {
		logic               ins;
		logic               pop;
		logic signed [31:0] value;
	} cell_ctl_t;

endpackage

[rtl/core/spq_cell.sv]
module spq_cell
	import spq_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic               clk,
	input  cell_ctl_t          ctl,
	input  logic [CW-1:0]      cnt,
	input  logic signed [31:0] left_entry,
	input  logic               left_lt,
	input  logic signed [31:0] right_entry,
	output logic signed [31:0] entry,
	output logic               lt
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic signed [31:0] entry_q;
	logic               occupied;

	// this cell holds a live entry that stays ahead of the new value
	assign occupied = (cnt > IDX_C);
	assign lt       = occupied && (entry_q < ctl.value);
	assign entry    = entry_q;

	// keep, shift toward tail, take the new value, or shift toward head
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt) begin
			entry_q <= left_lt ? ctl.value : left_entry;
		end else if (ctl.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

[rtl/core/sorted_insert_priority_queue_top.sv]
// Sorted priority queue of up to DEPTH signed 32-bit values, held in a row of
// cells in ascending order. A command is taken on any cycle with start high;
// busy never rises, so one command can be issued every clock. Each command
// gives one result on the cycle after it is taken, marked by done; the
// receiver cannot stall it. An insert lands ahead of equal entries already
// held; an insert into a full queue is dropped with status full, and a pop on
// an empty queue returns status empty. Every cell compares against the new
// value and shifts in the same cycle, so an insert or pop updates the whole
// row at once regardless of fill. No clearing pass is needed after reset.
module sorted_insert_priority_queue_top
	import spq_pkg::*;
#(
	parameter int DEPTH = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_nxt;
	logic               done_q;
	result_t            result_q;
	result_t            result_nxt;
	cell_ctl_t          ctl;
	logic               take;
	logic               is_full;
	logic               is_empty;
	logic [CW+4:0]      count_ext;
	logic signed [31:0] entries [DEPTH];
	logic               lts     [DEPTH];

	assign busy     = 1'b0;
	assign take     = start && !busy;
	assign is_full  = (count_q == DEPTH_C);
	assign is_empty = (count_q == '0);

	// decode the command into cell control
	always_comb begin
		ctl.ins   = take && (cmd.opcode == OP_INSERT) && !is_full;
		ctl.pop   = take && (cmd.opcode == OP_POP) && !is_empty;
		ctl.value = cmd.value;
	end

	// row of cells; the head sees a boundary on its left
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] left_e;
		logic               left_l;
		logic signed [31:0] right_e;

		if (i == 0) begin : g_head
			assign left_e = '0;
			assign left_l = 1'b1;
		end else begin : g_mid
			assign left_e = entries[i-1];
			assign left_l = lts[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign right_e = '0;
		end else begin : g_body
			assign right_e = entries[i+1];
		end

		spq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.cnt         (count_q),
			.left_entry  (left_e),
			.left_lt     (left_l),
			.right_entry (right_e),
			.entry       (entries[i]),
			.lt          (lts[i])
		);
	end

	// next count and result fields
	always_comb begin
		count_nxt = count_q;
		if (ctl.ins) begin
			count_nxt = count_q + CW'(1);
		end else if (ctl.pop) begin
			count_nxt = count_q - CW'(1);
		end
		count_ext = {5'd0, count_nxt};

		result_nxt.popped_value = '0;
		result_nxt.popped_valid = 1'b0;
		result_nxt.status       = ST_OK;
		result_nxt.entry_count  = count_ext[4:0];
		case (cmd.opcode)
			OP_INSERT: begin
				if (is_full) begin
					result_nxt.status = ST_FULL;
				end
			end
			OP_POP: begin
				if (is_empty) begin
					result_nxt.status = ST_EMPTY;
				end else begin
					result_nxt.popped_value = entries[0];
					result_nxt.popped_valid = 1'b1;
				end
			end
			default: begin
				result_nxt.status = ST_OK;
			end
		endcase
	end

	// count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= take;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= result_nxt;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	// occupancy never passes capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("occupancy above capacity");

	// every taken command gives a result next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> done)
		else $error("missing result strobe");

	// a popped entry always shrinks the count by one
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |=> (count_q == $past(count_q) - CW'(1)))
		else $error("pop did not shrink occupancy");

	// a dropped insert leaves the count at capacity
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> (count_q == DEPTH_C))
		else $error("full status with room left");

	// a valid pop always reports ok
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.popped_valid) |-> (result.status == ST_OK))
		else $error("popped entry with error status");

endmodule
